[hdl/aarm_pkg.sv]
// Package for the axis-angle rotation matrix block: CORDIC constants and shared types.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
package aarm_pkg;

   localparam int AXIS_BITS   = 16;
   localparam int ANGLE_BITS  = 16;
   localparam int ELEM_BITS   = 16;
   localparam int ATAN_LEN    = 24;
   localparam int FRAC_Q      = 30;
   localparam int CW          = 36;

   localparam logic signed [CW-1:0] INV_GAIN_Q30 = 36'sd652032874;
   localparam logic signed [CW-1:0] PI_Q30       = 36'sd3373259426;
   localparam logic signed [CW-1:0] HALF_PI_Q30  = 36'sd1686629713;

   typedef logic signed [AXIS_BITS-1:0]  axis_type;
   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   typedef logic signed [ELEM_BITS-1:0]  elem_type;
   typedef logic signed [CW-1:0]         cord_type;

   typedef struct packed {
      axis_type  axis_x;
      axis_type  axis_y;
      axis_type  axis_z;
      angle_type angle;
   } req_type;

   typedef struct packed {
      elem_type elem0;
      elem_type elem1;
      elem_type elem2;
      elem_type elem3;
      elem_type elem4;
      elem_type elem5;
      elem_type elem6;
      elem_type elem7;
      elem_type elem8;
   } rsp_type;

   function automatic cord_type atan_q30(input logic [4:0] idx);
      cord_type r;
      unique case (idx)
         5'd0:  r = 36'sd843314856;
         5'd1:  r = 36'sd497837829;
         5'd2:  r = 36'sd263043836;
         5'd3:  r = 36'sd133525158;
         5'd4:  r = 36'sd67021686;
         5'd5:  r = 36'sd33543515;
         5'd6:  r = 36'sd16775850;
         5'd7:  r = 36'sd8388437;
         5'd8:  r = 36'sd4194282;
         5'd9:  r = 36'sd2097149;
         5'd10: r = 36'sd1048575;
         5'd11: r = 36'sd524287;
         5'd12: r = 36'sd262143;
         5'd13: r = 36'sd131071;
         5'd14: r = 36'sd65535;
         5'd15: r = 36'sd32767;
         5'd16: r = 36'sd16383;
         5'd17: r = 36'sd8191;
         5'd18: r = 36'sd4095;
         5'd19: r = 36'sd2047;
         5'd20: r = 36'sd1023;
         5'd21: r = 36'sd511;
         5'd22: r = 36'sd255;
         5'd23: r = 36'sd127;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[hdl/aarm_req_if.sv]
// Valid/ready channel interface for requests.
// Depends on aarm_pkg.
`timescale 1ns / 1ps
interface aarm_req_if;
   import aarm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hdl/aarm_rsp_if.sv]
// Valid/ready channel interface for the nine-element result.
// Depends on aarm_pkg.
`timescale 1ns / 1ps
interface aarm_rsp_if;
   import aarm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hdl/aarm_cordic.sv]
// Unrolled rotation-mode CORDIC, one registered stage per step, with stall enable.
// Depends on aarm_pkg.
`timescale 1ns / 1ps
module aarm_cordic #(
   parameter int STEPS = 16
) (
   input  logic                 clock,
   input  logic                 enable,
   input  aarm_pkg::cord_type   z_start,
   output aarm_pkg::cord_type   cos_out,
   output aarm_pkg::cord_type   sin_out
);
   import aarm_pkg::*;

   cord_type x_ff [1:STEPS];
   cord_type y_ff [1:STEPS];
   cord_type z_ff [1:STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      cord_type x_cur, y_cur, z_cur;
      cord_type x_in, y_in, z_in;
      if (i == 0) begin : g_first
         assign x_cur = INV_GAIN_Q30;
         assign y_cur = '0;
         assign z_cur = z_start;
      end else begin : g_next
         assign x_cur = x_ff[i];
         assign y_cur = y_ff[i];
         assign z_cur = z_ff[i];
      end
      always_comb begin
         if (!z_cur[CW-1]) begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            z_in = z_cur - atan_q30(5'(i));
         end else begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            z_in = z_cur + atan_q30(5'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
         end
      end
   end

   assign cos_out = x_ff[STEPS];
   assign sin_out = y_ff[STEPS];
endmodule

[hdl/axis_angle_rotation_matrix.sv]
// Top level: axis-angle to 3x3 rotation matrix (Rodrigues) in a stalling pipeline.
// Depends on aarm_pkg, aarm_req_if, aarm_rsp_if and aarm_cordic.
//
//   channel  | dir | payload
//   req      | in  | axis_x, axis_y, axis_z (Q1.15), angle (Q3.13)
//   rsp      | out | elem0 .. elem8 (Q1.15, saturated)
//
// One transaction enters per cycle while the pipeline advances; the pipeline is
// one register per CORDIC step plus range fold, rounding, two multiply stages,
// and one stage for sum and saturation. The whole pipeline advances together
// when the output register is empty or taken. Reset clears only the valid bits.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic       clock,
   input  logic       reset,
   aarm_req_if.sink   req,
   aarm_rsp_if.source rsp
);
   import aarm_pkg::*;

   localparam int STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int DEPTH = STEPS + 5;
   localparam int F     = 15;
   localparam int SW    = 17;
   localparam int PW    = 64;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             adv;

   assign adv       = !vld_ff[DEPTH-1] || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = vld_ff[DEPTH-1];

   always_comb begin
      vld_in = {vld_ff[DEPTH-2:0], req.valid};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: range fold.
   cord_type z_raw, z_in, z_ff;
   logic     flip_in;
   assign z_raw = cord_type'(req.data.angle) <<< (FRAC_Q - 13);
   always_comb begin
      priority if (z_raw > HALF_PI_Q30) begin
         z_in = z_raw - PI_Q30; flip_in = 1'b1;
      end else if (z_raw < -HALF_PI_Q30) begin
         z_in = z_raw + PI_Q30; flip_in = 1'b1;
      end else begin
         z_in = z_raw; flip_in = 1'b0;
      end
   end

   axis_type ax_d [STEPS+2];
   axis_type ay_d [STEPS+2];
   axis_type az_d [STEPS+2];
   logic     fl_d [STEPS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         z_ff     <= z_in;
         ax_d[0]  <= req.data.axis_x;
         ay_d[0]  <= req.data.axis_y;
         az_d[0]  <= req.data.axis_z;
         fl_d[0]  <= flip_in;
         for (int k = 1; k < STEPS + 2; k++) begin
            ax_d[k] <= ax_d[k-1];
            ay_d[k] <= ay_d[k-1];
            az_d[k] <= az_d[k-1];
         end
         for (int k = 1; k < STEPS + 1; k++) begin
            fl_d[k] <= fl_d[k-1];
         end
      end
   end

   cord_type cx, cy;
   aarm_cordic #(.STEPS(STEPS)) u_cordic (
      .clock   (clock),
      .enable  (adv),
      .z_start (z_ff),
      .cos_out (cx),
      .sin_out (cy)
   );

   // Rounding to Q.15 with the half-turn negation.
   logic signed [CW-1:0] cr, sr;
   logic signed [SW-1:0] c_ff, s_ff;
   logic signed [SW:0]   omc_ff;
   logic                 fl;
   assign fl = fl_d[STEPS];
   assign cr = ((fl ? -cx : cx) + (CW'(1) <<< (FRAC_Q - F - 1))) >>> (FRAC_Q - F);
   assign sr = ((fl ? -cy : cy) + (CW'(1) <<< (FRAC_Q - F - 1))) >>> (FRAC_Q - F);

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff   <= SW'(cr);
         s_ff   <= SW'(sr);
         omc_ff <= (SW+1)'((CW'(1) <<< F) - cr);
      end
   end

   // Products of axis components, then weighted.
   axis_type ax, ay, az;
   assign ax = ax_d[STEPS+1];
   assign ay = ay_d[STEPS+1];
   assign az = az_d[STEPS+1];

   logic signed [31:0] pxx_ff, pyy_ff, pzz_ff, pxy_ff, pxz_ff, pyz_ff;
   logic signed [32:0] sx_ff, sy_ff, sz_ff;
   logic signed [SW:0]   omc2_ff;
   logic signed [SW-1:0] c2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         pxx_ff  <= ax * ax;
         pyy_ff  <= ay * ay;
         pzz_ff  <= az * az;
         pxy_ff  <= ax * ay;
         pxz_ff  <= ax * az;
         pyz_ff  <= ay * az;
         sx_ff   <= s_ff * ax;
         sy_ff   <= s_ff * ay;
         sz_ff   <= s_ff * az;
         omc2_ff <= omc_ff;
         c2_ff   <= c_ff;
      end
   end

   logic signed [PW-1:0] txx_ff, tyy_ff, tzz_ff, txy_ff, txz_ff, tyz_ff;
   logic signed [PW-1:0] sx3_ff, sy3_ff, sz3_ff, c30_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         txx_ff <= PW'(omc2_ff * pxx_ff);
         tyy_ff <= PW'(omc2_ff * pyy_ff);
         tzz_ff <= PW'(omc2_ff * pzz_ff);
         txy_ff <= PW'(omc2_ff * pxy_ff);
         txz_ff <= PW'(omc2_ff * pxz_ff);
         tyz_ff <= PW'(omc2_ff * pyz_ff);
         sx3_ff <= PW'(sx_ff) <<< 15;
         sy3_ff <= PW'(sy_ff) <<< 15;
         sz3_ff <= PW'(sz_ff) <<< 15;
         c30_ff <= PW'(c2_ff) <<< FRAC_Q;
      end
   end

   function automatic elem_type to_q15(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] r;
      r = (v + (PW'(1) <<< (F + 14))) >>> (F + 15);
      if (r > PW'(32767)) return 16'sh7fff;
      if (r < -PW'(32768)) return 16'sh8000;
      return r[15:0];
   endfunction

   rsp_type rsp_in, rsp_ff;
   always_comb begin
      rsp_in.elem0 = to_q15(txx_ff + c30_ff);
      rsp_in.elem1 = to_q15(txy_ff + sz3_ff);
      rsp_in.elem2 = to_q15(txz_ff - sy3_ff);
      rsp_in.elem3 = to_q15(txy_ff - sz3_ff);
      rsp_in.elem4 = to_q15(tyy_ff + c30_ff);
      rsp_in.elem5 = to_q15(tyz_ff + sx3_ff);
      rsp_in.elem6 = to_q15(txz_ff + sy3_ff);
      rsp_in.elem7 = to_q15(tyz_ff - sx3_ff);
      rsp_in.elem8 = to_q15(tzz_ff + c30_ff);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end
   assign rsp.data = rsp_ff;
endmodule
